### rtl/sitda_pkg.sv
// Shared types and constants for the signed integer to decimal ASCII converter.
// No dependencies; every other file in the folder refers to it by scoped names.

package sitda_pkg;

    // ASCII codes that the converter emits.
    localparam logic [7:0] CHAR_ZERO  = 8'd48;
    localparam logic [7:0] CHAR_MINUS = 8'd45;

    // Width of one BCD digit.
    localparam int unsigned DIGIT_W = 4;

    // Sequencer states of the top level.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONV,
        ST_EMIT
    } t_state;

    // Command from the sequencer to the character emitter.
    typedef struct packed {
        logic start;
        logic negative;
    } t_emit_cmd;

endpackage

### rtl/sitda_dabble.sv
// Bit-serial binary to BCD converter (shift and add three), one bit per cycle.
// Depends on sitda_pkg for the digit width.

module sitda_dabble #(
    parameter int unsigned MAG_BITS = 32,
    parameter int unsigned DIGITS   = 10
) (
    input  logic                                      i_clk,
    input  logic                                      i_rst_n,
    input  logic                                      i_start,
    input  logic [MAG_BITS-1:0]                       i_mag,
    output logic                                      o_done,
    output logic [DIGITS*sitda_pkg::DIGIT_W-1:0]      o_bcd
);

    localparam int unsigned BCD_W = DIGITS * sitda_pkg::DIGIT_W;
    localparam int unsigned CNT_W = $clog2(MAG_BITS + 1);

    logic [MAG_BITS-1:0] r_shift, n_shift;
    logic [BCD_W-1:0]    r_bcd, n_bcd;
    logic [BCD_W-1:0]    adj;
    logic [CNT_W-1:0]    r_cnt, n_cnt;
    logic                r_busy, n_busy;
    logic                r_done, n_done;

    // Add three to every digit of five or more before the next shift.
    always_comb begin
        for (int k = 0; k < DIGITS; k++) begin
            if (r_bcd[k*sitda_pkg::DIGIT_W +: sitda_pkg::DIGIT_W] >= 4'd5) begin
                adj[k*sitda_pkg::DIGIT_W +: sitda_pkg::DIGIT_W] =
                    r_bcd[k*sitda_pkg::DIGIT_W +: sitda_pkg::DIGIT_W] + 4'd3;
            end else begin
                adj[k*sitda_pkg::DIGIT_W +: sitda_pkg::DIGIT_W] =
                    r_bcd[k*sitda_pkg::DIGIT_W +: sitda_pkg::DIGIT_W];
            end
        end
    end

    // Next state: load on start, otherwise shift one magnitude bit into the digits.
    always_comb begin
        n_shift = r_shift;
        n_bcd   = r_bcd;
        n_cnt   = r_cnt;
        n_busy  = r_busy;
        n_done  = 1'b0;
        if (i_start) begin
            n_shift = i_mag;
            n_bcd   = '0;
            n_cnt   = CNT_W'(MAG_BITS);
            n_busy  = 1'b1;
        end else if (r_busy) begin
            n_bcd   = {adj[BCD_W-2:0], r_shift[MAG_BITS-1]};
            n_shift = {r_shift[MAG_BITS-2:0], 1'b0};
            n_cnt   = r_cnt - CNT_W'(1);
            if (r_cnt == CNT_W'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    // Control state is reset; the data shift registers are not.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_shift <= n_shift;
        r_bcd   <= n_bcd;
    end

    assign o_done = r_done;
    assign o_bcd  = r_bcd;

endmodule

### rtl/sitda_emit.sv
// Character emitter: drops leading zeros, sends the sign and the digits through
// an output register. Depends on sitda_pkg for the command struct and ASCII codes.

module sitda_emit #(
    parameter int unsigned DIGITS = 10
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  sitda_pkg::t_emit_cmd                   i_cmd,
    input  logic [DIGITS*sitda_pkg::DIGIT_W-1:0]   i_bcd,
    output logic                                   o_done,
    output logic                                   o_out_valid,
    input  logic                                   i_out_stall,
    output logic [7:0]                             o_text_char,
    output logic                                   o_is_last
);

    localparam int unsigned BCD_W  = DIGITS * sitda_pkg::DIGIT_W;
    localparam int unsigned LEFT_W = $clog2(DIGITS + 1);

    logic [BCD_W-1:0]  r_digits, n_digits;
    logic [LEFT_W-1:0] r_left, n_left;
    logic              r_active, n_active;
    logic              r_skip, n_skip;
    logic              r_sign, n_sign;
    logic              r_out_valid, n_out_valid;
    logic [7:0]        r_char, n_char;
    logic              r_last, n_last;
    logic [3:0]        top_digit;
    logic              can_load;
    logic              done;

    assign top_digit = r_digits[BCD_W-1 -: sitda_pkg::DIGIT_W];
    assign can_load  = !r_out_valid || !i_out_stall;

    // Walk the digits from the most significant end, one per cycle; a stalled output holds the emission.
    always_comb begin
        n_digits    = r_digits;
        n_left      = r_left;
        n_active    = r_active;
        n_skip      = r_skip;
        n_sign      = r_sign;
        n_out_valid = r_out_valid && i_out_stall;
        n_char      = r_char;
        n_last      = r_last;
        done        = 1'b0;
        if (i_cmd.start) begin
            n_digits = i_bcd;
            n_left   = LEFT_W'(DIGITS);
            n_active = 1'b1;
            n_skip   = 1'b1;
            n_sign   = i_cmd.negative;
        end else if (r_active) begin
            if (r_skip) begin
                // Leading zeros are shifted out, keeping at least one digit.
                if (top_digit == 4'd0 && r_left != LEFT_W'(1)) begin
                    n_digits = r_digits << sitda_pkg::DIGIT_W;
                    n_left   = r_left - LEFT_W'(1);
                end else begin
                    n_skip = 1'b0;
                end
            end else if (can_load) begin
                n_out_valid = 1'b1;
                if (r_sign) begin
                    n_char = sitda_pkg::CHAR_MINUS;
                    n_last = 1'b0;
                    n_sign = 1'b0;
                end else begin
                    n_char   = sitda_pkg::CHAR_ZERO + {4'd0, top_digit};
                    n_last   = (r_left == LEFT_W'(1));
                    n_digits = r_digits << sitda_pkg::DIGIT_W;
                    n_left   = r_left - LEFT_W'(1);
                    if (r_left == LEFT_W'(1)) begin
                        n_active = 1'b0;
                        done     = 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active    <= 1'b0;
            r_skip      <= 1'b0;
            r_sign      <= 1'b0;
            r_out_valid <= 1'b0;
            r_left      <= '0;
        end else begin
            r_active    <= n_active;
            r_skip      <= n_skip;
            r_sign      <= n_sign;
            r_out_valid <= n_out_valid;
            r_left      <= n_left;
        end
        r_digits <= n_digits;
        r_char   <= n_char;
        r_last   <= n_last;
    end

    assign o_done      = done;
    assign o_out_valid = r_out_valid;
    assign o_text_char = r_char;
    assign o_is_last   = r_last;

endmodule

### rtl/signed_integer_to_decimal_ascii.sv
// Signed binary integer to decimal ASCII text converter.
// Depends on sitda_pkg, sitda_dabble and sitda_emit.
//
// Usage:
//   The input channel (i_in_valid, o_in_stall, i_value) takes one two's
//   complement integer per transaction. The output channel (o_out_valid,
//   i_out_stall, o_text_char, o_is_last) returns its decimal text one
//   character per transaction, minus sign first for negative values, no
//   leading zeros, and o_is_last set on the final character.
//   Timing: the magnitude is shifted into BCD one bit per cycle; the first
//   character follows the conversion and the dropping of each leading zero
//   (the BCD register holds DIGITS digits).
//   Items are converted one at a time by the bit-serial shift-and-add-three
//   loop; a negative value emits one extra character for its sign. A new
//   item is taken in the cycle after the last character has entered the
//   output register.
//   Reset (synchronous, active low) empties the output register and returns
//   the sequencer to idle. While the receiver stalls, the held character
//   stays put and the emitter waits.

module signed_integer_to_decimal_ascii #(
    parameter int unsigned VALUE_BITS = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [VALUE_BITS-1:0] i_value,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [7:0]            o_text_char,
    output logic                  o_is_last
);

    // Decimal digits of 2^(VALUE_BITS-1), using log10(2) ~ 0.30103.
    localparam int unsigned DIGITS = ((VALUE_BITS - 1) * 30103) / 100000 + 1;
    localparam int unsigned BCD_W  = DIGITS * sitda_pkg::DIGIT_W;

    sitda_pkg::t_state    r_state, n_state;
    sitda_pkg::t_emit_cmd emit_cmd;
    logic                  r_neg;
    logic                  in_accept;
    logic [VALUE_BITS-1:0] magnitude;
    logic                  dab_done;
    logic                  emit_done;
    logic [BCD_W-1:0]      bcd;

    assign in_accept = i_in_valid && !o_in_stall;

    // Unsigned magnitude, so the most negative value converts correctly.
    assign magnitude = i_value[VALUE_BITS-1] ? (~i_value + VALUE_BITS'(1)) : i_value;

    // Sequencer next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            sitda_pkg::ST_IDLE: if (in_accept) n_state = sitda_pkg::ST_CONV;
            sitda_pkg::ST_CONV: if (dab_done)  n_state = sitda_pkg::ST_EMIT;
            sitda_pkg::ST_EMIT: if (emit_done) n_state = sitda_pkg::ST_IDLE;
            default:            n_state = sitda_pkg::ST_IDLE;
        endcase
    end

    // Sequencer outputs.
    always_comb begin
        o_in_stall        = 1'b1;
        emit_cmd.start    = 1'b0;
        emit_cmd.negative = r_neg;
        unique case (r_state)
            sitda_pkg::ST_IDLE: o_in_stall = 1'b0;
            sitda_pkg::ST_CONV: emit_cmd.start = dab_done;
            sitda_pkg::ST_EMIT: o_in_stall = 1'b1;
            default:            o_in_stall = 1'b1;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sitda_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
        if (in_accept) begin
            r_neg <= i_value[VALUE_BITS-1];
        end
    end

    sitda_dabble #(
        .MAG_BITS (VALUE_BITS),
        .DIGITS   (DIGITS)
    ) u_dabble (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (in_accept),
        .i_mag   (magnitude),
        .o_done  (dab_done),
        .o_bcd   (bcd)
    );

    sitda_emit #(
        .DIGITS (DIGITS)
    ) u_emit (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (emit_cmd),
        .i_bcd       (bcd),
        .o_done      (emit_done),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_text_char (o_text_char),
        .o_is_last   (o_is_last)
    );

endmodule

### rtl/sitda_checker.sv
// Port-level checks for the signed integer to decimal ASCII converter.
// Depends on sitda_pkg; bound to signed_integer_to_decimal_ascii below.

module sitda_checker #(
    parameter int unsigned VALUE_BITS = 32
) (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_in_valid,
    input logic                  o_in_stall,
    input logic                  o_out_valid,
    input logic                  i_out_stall,
    input logic [7:0]            o_text_char,
    input logic                  o_is_last
);

    // A stalled result stays valid.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> o_out_valid)
        else $error("result dropped while stalled");

    // A stalled result keeps its payload.
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> ($stable(o_text_char) && $stable(o_is_last)))
        else $error("result payload changed while stalled");

    // Only a minus sign or a decimal digit is ever emitted.
    a_char_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_text_char == sitda_pkg::CHAR_MINUS ||
                         (o_text_char >= sitda_pkg::CHAR_ZERO &&
                          o_text_char <= sitda_pkg::CHAR_ZERO + 8'd9)))
        else $error("character outside the decimal set");

    // The sign is never the final character of a number.
    a_sign_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_text_char == sitda_pkg::CHAR_MINUS) |-> !o_is_last)
        else $error("minus sign flagged as last character");

    // After a transaction is taken, the converter is busy in the next cycle.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input taken again straight after a transaction");

endmodule

bind signed_integer_to_decimal_ascii sitda_checker #(
    .VALUE_BITS (VALUE_BITS)
) u_sitda_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_text_char (o_text_char),
    .o_is_last   (o_is_last)
);
